### hw/rtl/tcbr_pkg.sv
package tcbr_pkg;

  localparam int unsigned CoordWidth = 24;
  localparam int unsigned FracBits   = 12;
  localparam int unsigned PropWidth  = 8;
  localparam int unsigned CfgWidth   = 8;
  localparam int unsigned CfgIdxWidth = 1;

  localparam logic [CfgIdxWidth-1:0] CfgSelectedProp = 1'd0;
  localparam logic [CfgIdxWidth-1:0] CfgFastMode     = 1'd1;

  localparam logic [1:0] CornerLast = 2'd3;

endpackage

### hw/rtl/tcbr_vertex_if.sv
interface tcbr_vertex_if #(
  parameter int unsigned CoordWidth = tcbr_pkg::CoordWidth
);
  logic                               valid;
  logic                               ready;
  logic signed [CoordWidth-1:0]       vertex_x;
  logic signed [CoordWidth-1:0]       vertex_y;
  logic signed [CoordWidth-1:0]       vertex_z;
  logic [1:0]                         corner_index;
  logic [tcbr_pkg::PropWidth-1:0]     element_prop;
  logic                               boundary_positive;
  logic                               last_element;

  modport source (output valid, vertex_x, vertex_y, vertex_z, corner_index, element_prop,
                  boundary_positive, last_element, input ready);
  modport sink (input valid, vertex_x, vertex_y, vertex_z, corner_index, element_prop,
                boundary_positive, last_element, output ready);
endinterface

### hw/rtl/tcbr_result_if.sv
interface tcbr_result_if #(
  parameter int unsigned CoordWidth = tcbr_pkg::CoordWidth
);
  logic                         valid;
  logic                         ready;
  logic                         written;
  logic signed [CoordWidth-1:0] centroid_x;
  logic signed [CoordWidth-1:0] centroid_y;
  logic signed [CoordWidth-1:0] centroid_z;
  logic [CoordWidth+1:0]        bound_radius;
  logic                         last_out;

  modport source (output valid, written, centroid_x, centroid_y, centroid_z, bound_radius,
                  last_out, input ready);
  modport sink (input valid, written, centroid_x, centroid_y, centroid_z, bound_radius,
                last_out, output ready);
endinterface

### hw/rtl/tcbr_front.sv
// Holds corners 0..2 and, on corner 3, pushes a complete element into the queue.
module tcbr_front #(
  parameter int unsigned CoordWidth = tcbr_pkg::CoordWidth
) (
  input  logic                           clk_i,
  tcbr_vertex_if.sink                    in_if,
  input  logic [tcbr_pkg::PropWidth-1:0] selected_prop_i,
  input  logic                           fast_mode_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output logic [12*CoordWidth+1:0]       q_data_o
);
  logic [CoordWidth-1:0] held_x_q [3];
  logic [CoordWidth-1:0] held_y_q [3];
  logic [CoordWidth-1:0] held_z_q [3];
  logic                  fire;
  logic                  keep;

  assign in_if.ready = !q_full_i;
  assign fire = in_if.valid && in_if.ready;
  assign q_push_o = fire && (in_if.corner_index == tcbr_pkg::CornerLast);
  assign keep = (in_if.element_prop == selected_prop_i) &&
                !(fast_mode_i && !in_if.boundary_positive);
  assign q_data_o = {keep, in_if.last_element,
                     held_x_q[0], held_x_q[1], held_x_q[2], in_if.vertex_x,
                     held_y_q[0], held_y_q[1], held_y_q[2], in_if.vertex_y,
                     held_z_q[0], held_z_q[1], held_z_q[2], in_if.vertex_z};

  // The holding registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (fire && in_if.corner_index != tcbr_pkg::CornerLast) begin
      held_x_q[in_if.corner_index] <= in_if.vertex_x;
      held_y_q[in_if.corner_index] <= in_if.vertex_y;
      held_z_q[in_if.corner_index] <= in_if.vertex_z;
    end
  end
endmodule

### hw/rtl/tcbr_fifo.sv
module tcbr_fifo #(
  parameter int unsigned Width = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);
  logic [Width-1:0] mem_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) empty_o |-> !pop_i)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
endmodule

### hw/rtl/tcbr_back.sv
// Sequencer: sum, four squared distances one per cycle, then a bit-pair square root.
module tcbr_back #(
  parameter int unsigned CoordWidth = tcbr_pkg::CoordWidth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_empty_i,
  input  logic [12*CoordWidth+1:0] q_data_i,
  output logic                     q_pop_o,
  tcbr_result_if.source            out_if
);
  localparam int unsigned SumW = CoordWidth + 2;
  localparam int unsigned DifW = CoordWidth + 3;
  localparam int unsigned SqW  = 2 * DifW + 2;
  localparam int unsigned RadW = CoordWidth + 2;
  localparam int unsigned RemW = SqW + 2;

  typedef enum logic [2:0] {SIdle, SCent, SDist, SRoot, SOut} state_e;

  state_e                 state_q;
  logic [1:0]             idx_q;
  logic [$clog2(RadW)-1:0] step_q;
  logic signed [CoordWidth-1:0] px_q [4], py_q [4], pz_q [4];
  logic signed [CoordWidth-1:0] cx_q, cy_q, cz_q;
  logic [SqW-1:0]         best_q;
  logic [RemW-1:0]        rem_q;
  logic [RadW-1:0]        root_q;
  logic                   keep_q, last_q;

  logic signed [SumW-1:0] sx, sy, sz;
  logic signed [DifW-1:0] dx, dy, dz;
  logic [DifW-1:0]        ax, ay, az;
  logic [2*DifW-1:0]      sqx, sqy, sqz;
  logic [SqW-1:0]         d2;
  logic [RemW-1:0]        trial, rem_sh;
  logic [1:0]             pair;

  assign sx = SumW'(px_q[0]) + SumW'(px_q[1]) + SumW'(px_q[2]) + SumW'(px_q[3]);
  assign sy = SumW'(py_q[0]) + SumW'(py_q[1]) + SumW'(py_q[2]) + SumW'(py_q[3]);
  assign sz = SumW'(pz_q[0]) + SumW'(pz_q[1]) + SumW'(pz_q[2]) + SumW'(pz_q[3]);

  assign dx = DifW'(cx_q) - DifW'(px_q[idx_q]);
  assign dy = DifW'(cy_q) - DifW'(py_q[idx_q]);
  assign dz = DifW'(cz_q) - DifW'(pz_q[idx_q]);
  assign ax = dx[DifW-1] ? -dx : dx;
  assign ay = dy[DifW-1] ? -dy : dy;
  assign az = dz[DifW-1] ? -dz : dz;
  assign sqx = ax * ax;
  assign sqy = ay * ay;
  assign sqz = az * az;
  assign d2 = SqW'(sqx) + SqW'(sqy) + SqW'(sqz);

  // One result bit per cycle, most significant bit pair first.
  assign pair   = 2'(best_q >> (2 * (RadW - 1 - step_q)));
  assign rem_sh = {rem_q[RemW-3:0], pair};
  assign trial  = RemW'({root_q, 2'b01});

  assign q_pop_o = (state_q == SIdle) && !q_empty_i;
  assign out_if.valid = state_q == SOut;
  assign out_if.written = keep_q;
  assign out_if.last_out = last_q;
  assign out_if.centroid_x = keep_q ? cx_q : '0;
  assign out_if.centroid_y = keep_q ? cy_q : '0;
  assign out_if.centroid_z = keep_q ? cz_q : '0;
  assign out_if.bound_radius = keep_q ? root_q : '0;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      {keep_q, last_q} <= q_data_i[12*CoordWidth+1 -: 2];
      for (int i = 0; i < 4; i++) begin
        px_q[i] <= q_data_i[12*CoordWidth-1-i*CoordWidth -: CoordWidth];
        py_q[i] <= q_data_i[8*CoordWidth-1-i*CoordWidth -: CoordWidth];
        pz_q[i] <= q_data_i[4*CoordWidth-1-i*CoordWidth -: CoordWidth];
      end
    end
    if (state_q == SCent) begin
      cx_q <= CoordWidth'(sx >>> 2);
      cy_q <= CoordWidth'(sy >>> 2);
      cz_q <= CoordWidth'(sz >>> 2);
      best_q <= '0;
      rem_q <= '0;
      root_q <= '0;
    end
    if (state_q == SDist && d2 > best_q) best_q <= d2;
    if (state_q == SRoot) begin
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[RadW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[RadW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      idx_q <= '0;
      step_q <= '0;
    end else begin
      unique case (state_q)
        SIdle: if (!q_empty_i) state_q <= SCent;
        SCent: begin
          idx_q <= '0;
          state_q <= SDist;
        end
        SDist: begin
          idx_q <= idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            step_q <= '0;
            state_q <= SRoot;
          end
        end
        SRoot: begin
          step_q <= step_q + 1'b1;
          if (step_q == $bits(step_q)'(RadW - 1)) state_q <= SOut;
        end
        SOut: if (out_if.ready) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SDist && idx_q == 2'd3) |=> state_q == SRoot)
    else $error("distance scan did not end in root");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> out_if.valid && $stable(root_q))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> state_q == SCent)
    else $error("pop without start");
endmodule

### hw/rtl/tetra_centroid_bounding_radius.sv
// Corners 0..2 are held by the front, one per cycle while the queue is not full; corner 3
// pushes the element. The back part then forms the centroid, the four squared distances
// and the square root that yields one bit per cycle, and pops the next element only when idle.
// A two-entry queue lets the front keep taking corners while the back works.
// Reset (rst_ni, asynchronous, active low) clears control and configuration; held
// corners are not cleared.
module tetra_centroid_bounding_radius #(
  parameter int unsigned CoordWidth = tcbr_pkg::CoordWidth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tcbr_vertex_if.sink                    in_if,
  tcbr_result_if.source                  out_if,
  input  logic                           cfg_we_i,
  input  logic [tcbr_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [tcbr_pkg::CfgWidth-1:0]  cfg_data_i
);
  localparam int unsigned QW = 12 * CoordWidth + 2;

  logic [tcbr_pkg::PropWidth-1:0] selected_prop_q;
  logic                           fast_mode_q;
  logic                           q_full, q_empty, q_push, q_pop;
  logic [QW-1:0]                  q_in, q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      selected_prop_q <= '0;
      fast_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tcbr_pkg::CfgSelectedProp: selected_prop_q <= cfg_data_i;
        tcbr_pkg::CfgFastMode:     fast_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tcbr_front #(.CoordWidth(CoordWidth)) u_front (
    .clk_i, .in_if,
    .selected_prop_i(selected_prop_q), .fast_mode_i(fast_mode_q),
    .q_full_i(q_full), .q_push_o(q_push), .q_data_o(q_in)
  );

  tcbr_fifo #(.Width(QW)) u_fifo (
    .clk_i, .rst_ni, .push_i(q_push), .data_i(q_in), .full_o(q_full),
    .pop_i(q_pop), .empty_o(q_empty), .data_o(q_out)
  );

  tcbr_back #(.CoordWidth(CoordWidth)) u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .q_data_i(q_out), .q_pop_o(q_pop), .out_if
  );
endmodule

### bench/tetra_centroid_bounding_radius_tb.sv
`timescale 1ns / 100ps

module tetra_centroid_bounding_radius_tb;

  localparam int unsigned RadWidth = tcbr_pkg::CoordWidth + 2;
  localparam int unsigned DrainCycles = 2 + 4 + RadWidth + 1 + 20;
  localparam int unsigned CycleLimit = 400000;

  typedef logic signed [tcbr_pkg::CoordWidth-1:0] coord_t;

  typedef struct packed {
    coord_t           x;
    coord_t           y;
    coord_t           z;
    logic [1:0]       corner;
    logic [tcbr_pkg::PropWidth-1:0] prop;
    logic             bpos;
    logic             last;
  } vertex_t;

  typedef struct packed {
    logic                written;
    coord_t              cx;
    coord_t              cy;
    coord_t              cz;
    logic [RadWidth-1:0] radius;
    logic                last;
  } centroid_t;

  // A directed row: the vertex, whether its result is typed in, and that result.
  typedef struct packed {
    vertex_t   v;
    logic      fixed;
    centroid_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [tcbr_pkg::CfgIdxWidth-1:0] cfg_idx_i;
  logic [tcbr_pkg::CfgWidth-1:0] cfg_data_i;

  tcbr_vertex_if in_if ();
  tcbr_result_if out_if ();

  tetra_centroid_bounding_radius DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if.sink),
    .out_if     (out_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predictor state.
  coord_t corner_x [3];
  coord_t corner_y [3];
  coord_t corner_z [3];
  logic [tcbr_pkg::PropWidth-1:0] sel_prop;
  logic fast_on;

  centroid_t pending_centroids[$];
  int errors = 0;
  int cycles = 0;
  bit hold_off;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout at %0t", $time);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [RadWidth-1:0] floor_sqrt(logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[RadWidth-1:0];
  endfunction

  function automatic logic [63:0] dist_sq(longint dx, longint dy, longint dz);
    return 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
  endfunction

  // Updates the held corners and returns 1 with the centroid when the element completes.
  function automatic bit predict_centroid(vertex_t v, output centroid_t r);
    longint px [4];
    longint py [4];
    longint pz [4];
    longint cx;
    longint cy;
    longint cz;
    logic [63:0] d2;
    logic [63:0] best;
    r = '0;
    best = 0;
    if (v.corner != tcbr_pkg::CornerLast) begin
      corner_x[v.corner] = v.x;
      corner_y[v.corner] = v.y;
      corner_z[v.corner] = v.z;
      return 0;
    end
    r.last = v.last;
    if (v.prop != sel_prop || (fast_on && !v.bpos)) return 1;
    for (int i = 0; i < 3; i++) begin
      px[i] = corner_x[i];
      py[i] = corner_y[i];
      pz[i] = corner_z[i];
    end
    px[3] = v.x;
    py[3] = v.y;
    pz[3] = v.z;
    // The arithmetic shift is the floor of the quarter.
    cx = (px[0] + px[1] + px[2] + px[3]) >>> 2;
    cy = (py[0] + py[1] + py[2] + py[3]) >>> 2;
    cz = (pz[0] + pz[1] + pz[2] + pz[3]) >>> 2;
    for (int i = 0; i < 4; i++) begin
      d2 = dist_sq(cx - px[i], cy - py[i], cz - pz[i]);
      if (d2 > best) best = d2;
    end
    r.written = 1'b1;
    r.cx = coord_t'(cx);
    r.cy = coord_t'(cy);
    r.cz = coord_t'(cz);
    r.radius = floor_sqrt(best);
    return 1;
  endfunction

  // Receiver: stalls on its own pattern, with one long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= hold_off ? 1'b0 : (cycles % 700 < 150) ? 1'b1 : ($urandom_range(3) != 0);
    end
  end

  always @(posedge clk_i) begin
    centroid_t got;
    centroid_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = {out_if.written, out_if.centroid_x, out_if.centroid_y, out_if.centroid_z,
             out_if.bound_radius, out_if.last_out};
      if (pending_centroids.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        want = pending_centroids.pop_front();
        if (got.written !== want.written || got.cx !== want.cx || got.cy !== want.cy ||
            got.cz !== want.cz || got.radius !== want.radius || got.last !== want.last) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  task automatic send_vertex(vertex_t v);
    centroid_t r;
    in_if.valid <= 1'b1;
    {in_if.vertex_x, in_if.vertex_y, in_if.vertex_z, in_if.corner_index, in_if.element_prop,
     in_if.boundary_positive, in_if.last_element} <= v;
    do @(posedge clk_i); while (!in_if.ready);
    if (predict_centroid(v, r)) pending_centroids.push_back(r);
  endtask

  task automatic idle_cycles(int n);
    in_if.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // The write enable drops for a cycle so that back-to-back writes stay apart.
  task automatic write_reg(logic [tcbr_pkg::CfgIdxWidth-1:0] idx,
                           logic [tcbr_pkg::CfgWidth-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == tcbr_pkg::CfgSelectedProp) sel_prop = data;
    else fast_on = data[0];
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_centroids.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(5))
      0: return coord_t'({1'b1, {(tcbr_pkg::CoordWidth-1){1'b0}}});
      1: return coord_t'({1'b0, {(tcbr_pkg::CoordWidth-1){1'b1}}});
      2: return coord_t'($signed($urandom_range(8191)) - 4096);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic vertex_t rand_vertex(logic [1:0] corner, bit match);
    vertex_t v;
    v.x = rand_coord();
    v.y = rand_coord();
    v.z = rand_coord();
    v.corner = corner;
    v.prop = match ? sel_prop : tcbr_pkg::PropWidth'($urandom);
    v.bpos = $urandom_range(3) != 0;
    v.last = $urandom_range(7) == 0;
    return v;
  endfunction

  localparam coord_t CMax = {1'b0, {(tcbr_pkg::CoordWidth-1){1'b1}}};
  localparam coord_t CMin = {1'b1, {(tcbr_pkg::CoordWidth-1){1'b0}}};

  row_t directed_rows[$];

  initial begin
    row_t row;
    int burst;
    hold_off = 1'b0;
    sel_prop = '0;
    fast_on = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = tcbr_pkg::CfgSelectedProp;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    {in_if.vertex_x, in_if.vertex_y, in_if.vertex_z, in_if.corner_index, in_if.element_prop,
     in_if.boundary_positive, in_if.last_element} = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // All corners at the origin: centroid and radius zero after reset.
    for (int c = 0; c < 4; c++) begin
      row = '0;
      row.v.corner = 2'(c);
      row.v.last = (c == 3);
      row.fixed = (c == 3);
      row.res = {1'b1, 24'sd0, 24'sd0, 24'sd0, 26'd0, 1'b1};
      directed_rows.push_back(row);
    end
    // All corners at the positive extreme.
    for (int c = 0; c < 4; c++) begin
      row = '0;
      row.v = {CMax, CMax, CMax, 2'(c), 8'd0, 1'b1, 1'b0};
      row.fixed = (c == 3);
      row.res = {1'b1, CMax, CMax, CMax, 26'd0, 1'b0};
      directed_rows.push_back(row);
    end
    // Corners at opposite extremes: widest spread, checked by the predictor.
    for (int c = 0; c < 4; c++) begin
      row = '0;
      row.v = {(c[0] ? CMin : CMax), (c[1] ? CMin : CMax), CMin, 2'(c), 8'd0, 1'b0, 1'b0};
      directed_rows.push_back(row);
    end
    // Property mismatch: skipped, last still copied.
    row = '0;
    row.v = {CMax, CMin, CMax, tcbr_pkg::CornerLast, 8'hFF, 1'b1, 1'b1};
    row.fixed = 1'b1;
    row.res = {1'b0, 24'sd0, 24'sd0, 24'sd0, 26'd0, 1'b1};
    directed_rows.push_back(row);
    // A repeated corner overwrites its entry; then complete with negative values.
    row = '0;
    row.v = {-24'sd5, -24'sd7, 24'sd3, 2'd1, 8'd0, 1'b0, 1'b0};
    directed_rows.push_back(row);
    row.v = {-24'sd1, 24'sd2, -24'sd9, tcbr_pkg::CornerLast, 8'd0, 1'b0, 1'b0};
    directed_rows.push_back(row);

    foreach (directed_rows[i]) begin
      send_vertex(directed_rows[i].v);
      if (directed_rows[i].fixed) pending_centroids[$] = directed_rows[i].res;
    end
    drain();

    // Fast mode: a non-positive boundary is skipped.
    write_reg(tcbr_pkg::CfgFastMode, 8'd1);
    write_reg(tcbr_pkg::CfgSelectedProp, 8'hFF);
    for (int c = 0; c < 3; c++) send_vertex(rand_vertex(2'(c), 1'b1));
    row = '0;
    row.v = {CMin, CMin, CMin, tcbr_pkg::CornerLast, 8'hFF, 1'b0, 1'b0};
    send_vertex(row.v);
    row.v.bpos = 1'b1;
    send_vertex(row.v);
    drain();

    // Random phases over several settings.
    for (int phase = 0; phase < 5; phase++) begin
      write_reg(tcbr_pkg::CfgSelectedProp,
                (phase == 0) ? 8'h00 : (phase == 1) ? 8'hFF : 8'($urandom));
      write_reg(tcbr_pkg::CfgFastMode, 8'(phase % 2));
      if (phase == 2) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 100; ) begin
        burst = $urandom_range(12, 1);
        for (int b = 0; b < burst && n < 100; b++) begin
          if ($urandom_range(9) == 0) begin
            // Noise: a lone corner in any position.
            send_vertex(rand_vertex(2'($urandom), $urandom_range(1)));
            n++;
          end else begin
            bit match;
            match = $urandom_range(4) != 0;
            for (int c = 0; c < 4; c++) send_vertex(rand_vertex(2'(c), match));
            n += 4;
          end
        end
        if ($urandom_range(2) == 0) idle_cycles($urandom_range(6, 1));
      end
      drain();
    end

    if (errors == 0 && pending_centroids.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
